[rtl/assert_macros.svh]
// assert_macros.svh - assertion macros shared by the RTL files.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define AST_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AST_HOLDS(lbl, clk, rst_n, prop, msg)
`define AST_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[rtl/rcs_pkg.sv]
// rcs_pkg.sv - shared constants, op codes and control/status structs of the crossfader.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rcs_pkg;

    localparam int FADE_TICKS_DEF = 1020;

    localparam int NUM_CH  = 3;
    localparam int CH_W    = 2;
    localparam int LEVEL_W = 8;
    localparam int TGT_W   = 10;          // scaled target, up to 650
    localparam int GAP_W   = TGT_W + 1;   // signed target minus start
    localparam int DIVD_W  = 16;          // divider numerator width

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] PCT_SCALE = 8'd255;
    localparam logic [6:0]         PCT_DIV   = 7'd100;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_GAP,
        DIV_MOD
    } div_sel_t;

    typedef struct packed {
        logic            in_ready;
        logic            load_in;
        logic            div_start;
        div_sel_t        div_sel;
        logic [CH_W-1:0] ch;
        logic            wr_tgt;
        logic            wr_ivl;
        logic            step;
        logic            tick_end;
        logic            set_levels;
        logic            clr_count;
        logic            out_load;
    } rcs_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       count_over;
        logic       div_done;
        logic       gap_zero;
        logic       ivl_zero;
        logic       out_full;
    } rcs_stat_t;

endpackage

`default_nettype wire

[rtl/rcs_div.sv]
// rcs_div.sv - iterative restoring divider, one quotient bit per cycle.
// Depends on rcs_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module rcs_div import rcs_pkg::*; #(
    parameter int NUM_W = DIVD_W,
    parameter int DEN_W = TGT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  r_reg;
    logic [DEN_W-1:0]  d_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0] r_sh;
    logic [DEN_W:0] r_diff;
    logic           fits;

    assign r_sh   = {r_reg, q_reg[NUM_W-1]};
    assign fits   = r_sh >= {1'b0, d_reg};
    assign r_diff = r_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NUM_W-2:0], fits};
            r_reg <= fits ? r_diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

[rtl/rcs_dpath.sv]
// rcs_dpath.sv - crossfader datapath: levels, start colour, intervals, counter, output register.
// Depends on rcs_pkg and rcs_div; driven by rcs_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module rcs_dpath import rcs_pkg::*; #(
    parameter int FADE_TICKS = FADE_TICKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rcs_cmd_t                   cmd,
    output rcs_stat_t                  stat,
    input  logic [1:0]                 in_op,
    input  logic [NUM_CH*LEVEL_W-1:0]  in_rgb,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [NUM_CH*LEVEL_W-1:0]  out_rgb,
    output logic                       out_fading
);

    localparam int CNT_W = $clog2(FADE_TICKS + 2);
    localparam int IVL_W = $clog2(FADE_TICKS + 1);
    localparam int DEN_W = (IVL_W > TGT_W) ? IVL_W : TGT_W;

    logic [1:0]         in_op_reg;
    logic [LEVEL_W-1:0] in_ch_reg   [NUM_CH];
    logic [TGT_W-1:0]   tgt_reg     [NUM_CH];
    logic [LEVEL_W-1:0] lvl_reg     [NUM_CH];
    logic [LEVEL_W-1:0] start_reg   [NUM_CH];
    logic [IVL_W-1:0]   ivl_mag_reg [NUM_CH];
    logic               ivl_neg_reg [NUM_CH];
    logic [CNT_W-1:0]   count_reg;

    logic                       out_valid_reg;
    logic [NUM_CH*LEVEL_W-1:0]  out_rgb_reg;
    logic                       out_fading_reg;

    logic [GAP_W-1:0] gap;
    logic [GAP_W-1:0] gap_mag;
    logic             gap_neg;
    logic             gap_zero;
    logic             count_over;

    logic [DIVD_W-1:0] dvd;
    logic [DEN_W-1:0]  dvs;
    logic              div_done;
    logic [DIVD_W-1:0] quo;
    logic [DEN_W-1:0]  rem;

    // signed gap of the selected channel
    assign gap      = GAP_W'(tgt_reg[cmd.ch]) - GAP_W'(start_reg[cmd.ch]);
    assign gap_neg  = gap[GAP_W-1];
    assign gap_mag  = gap_neg ? (~gap + GAP_W'(1)) : gap;
    assign gap_zero = (gap == '0);

    assign count_over = count_reg > CNT_W'(FADE_TICKS);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SCALE:
            begin
                dvd = DIVD_W'(in_ch_reg[cmd.ch]) * DIVD_W'(PCT_SCALE);
                dvs = DEN_W'(PCT_DIV);
            end
            DIV_GAP:
            begin
                dvd = DIVD_W'(FADE_TICKS);
                dvs = DEN_W'(gap_mag[TGT_W-1:0]);
            end
            DIV_MOD:
            begin
                dvd = DIVD_W'(count_reg);
                dvs = DEN_W'(ivl_mag_reg[cmd.ch]);
            end
            default:
            begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    rcs_div #(
        .NUM_W (DIVD_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // item and scaled-target capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_op_reg <= in_op;
            for (int c = 0; c < NUM_CH; c++)
            begin
                in_ch_reg[c] <= in_rgb[c*LEVEL_W +: LEVEL_W];
            end
        end
        if (cmd.wr_tgt)
        begin
            tgt_reg[cmd.ch] <= quo[TGT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                lvl_reg[c]     <= '0;
                start_reg[c]   <= '0;
                ivl_mag_reg[c] <= '0;
                ivl_neg_reg[c] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.set_levels)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    lvl_reg[c]   <= in_ch_reg[c];
                    start_reg[c] <= in_ch_reg[c];
                end
            end
            else if (cmd.step && (rem == '0))
            begin
                if (ivl_neg_reg[cmd.ch])
                begin
                    if (lvl_reg[cmd.ch] != '0)
                    begin
                        lvl_reg[cmd.ch] <= lvl_reg[cmd.ch] - LEVEL_W'(1);
                    end
                end
                else if (lvl_reg[cmd.ch] != LEVEL_MAX)
                begin
                    lvl_reg[cmd.ch] <= lvl_reg[cmd.ch] + LEVEL_W'(1);
                end
            end

            if (cmd.wr_ivl)
            begin
                ivl_mag_reg[cmd.ch] <= gap_zero ? '0 : quo[IVL_W-1:0];
                ivl_neg_reg[cmd.ch] <= gap_neg;
            end

            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.tick_end)
            begin
                count_reg <= count_reg + CNT_W'(1);
                // last tick of the fade: next fade starts from here
                if (count_reg == CNT_W'(FADE_TICKS))
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        start_reg[c] <= lvl_reg[c];
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_rgb_reg    <= {lvl_reg[2], lvl_reg[1], lvl_reg[0]};
            out_fading_reg <= !count_over;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_rgb    = out_rgb_reg;
    assign out_fading = out_fading_reg;

    always_comb
    begin
        stat.op         = in_op_reg;
        stat.count_zero = (count_reg == '0);
        stat.count_over = count_over;
        stat.div_done   = div_done;
        stat.gap_zero   = gap_zero;
        stat.ivl_zero   = (ivl_mag_reg[cmd.ch] == '0);
        stat.out_full   = out_valid_reg;
    end

endmodule

`default_nettype wire

[rtl/rcs_ctrl.sv]
// rcs_ctrl.sv - crossfader sequencer: walks the three channels through the shared divider.
// Depends on rcs_pkg; drives rcs_dpath through rcs_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module rcs_ctrl import rcs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  rcs_stat_t stat,
    output rcs_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_GAP,
        ST_GAP_WAIT,
        ST_MOD,
        ST_MOD_WAIT,
        ST_TICK_END,
        ST_OUT
    } state_t;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CH_W-1:0] ch_reg;
    logic [CH_W-1:0] ch_next;
    logic            ch_last;

    assign ch_last = (ch_reg == CH_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        cmd         = '0;
        cmd.ch      = ch_reg;
        cmd.div_sel = DIV_SCALE;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                ch_next = '0;
                priority if (stat.op == OP_SET)
                begin
                    cmd.set_levels = 1'b1;
                    state_next     = ST_OUT;
                end
                else if (stat.op == OP_RESTART)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = ST_OUT;
                end
                else if (stat.op == OP_TICK)
                begin
                    priority if (stat.count_over)
                        state_next = ST_OUT;
                    else if (stat.count_zero)
                        state_next = ST_SCALE;
                    else
                        state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SCALE:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.wr_tgt = 1'b1;
                    ch_next    = ch_last ? '0 : ch_reg + CH_W'(1);
                    state_next = ch_last ? ST_GAP : ST_SCALE;
                end
            end
            ST_GAP:
            begin
                cmd.div_sel = DIV_GAP;
                if (stat.gap_zero)
                begin
                    cmd.wr_ivl = 1'b1;
                    ch_next    = ch_last ? '0 : ch_reg + CH_W'(1);
                    state_next = ch_last ? ST_MOD : ST_GAP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_GAP_WAIT;
                end
            end
            ST_GAP_WAIT:
            begin
                cmd.div_sel = DIV_GAP;
                if (stat.div_done)
                begin
                    cmd.wr_ivl = 1'b1;
                    ch_next    = ch_last ? '0 : ch_reg + CH_W'(1);
                    state_next = ch_last ? ST_MOD : ST_GAP;
                end
            end
            ST_MOD:
            begin
                cmd.div_sel = DIV_MOD;
                if (stat.ivl_zero)
                begin
                    ch_next    = ch_last ? '0 : ch_reg + CH_W'(1);
                    state_next = ch_last ? ST_TICK_END : ST_MOD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT:
            begin
                cmd.div_sel = DIV_MOD;
                if (stat.div_done)
                begin
                    cmd.step   = 1'b1;
                    ch_next    = ch_last ? '0 : ch_reg + CH_W'(1);
                    state_next = ch_last ? ST_TICK_END : ST_MOD;
                end
            end
            ST_TICK_END:
            begin
                cmd.tick_end = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/rgb_crossfade_stepper.sv]
// rgb_crossfade_stepper.sv - top level of the three-channel LED crossfader.
// Depends on rcs_pkg, rcs_ctrl, rcs_dpath (with rcs_div) and assert_macros.svh.
//
//  channel | dir | tdata                       | tuser
//  --------+-----+-----------------------------+-----------------------
//  s_*     | in  | red_in, green_in, blue_in   | op (0 tick, 1 set, 2 restart)
//  m_*     | out | red_out, green_out, blue_out| fading
//
// One item in flight; the next is taken once the current result is in the
// output register, even while that result still waits on m_tready.
// Set, restart and unused op run no division. A running fade tick makes up to
// three modulo runs of the shared divider, one per channel. The first tick of a
// fade adds scale and interval runs per channel.
// Reset clears levels, start colour, intervals and counter at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb_crossfade_stepper import rcs_pkg::*; #(
    parameter int FADE_TICKS = FADE_TICKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [0:0]  m_tuser    // [0] fading
);

    rcs_cmd_t  cmd;
    rcs_stat_t stat;
    logic      fading;

    // sequencer: one item at a time, divider shared across channels
    rcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // state, divider and result register
    rcs_dpath #(
        .FADE_TICKS (FADE_TICKS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_rgb     (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_rgb    (m_tdata),
        .out_fading (fading)
    );

    assign s_tready   = cmd.in_ready;
    assign m_tuser[0] = fading;

    // one item at a time: ready drops right after an accept
    `AST_HOLDS(a_one_in_flight, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "second item taken while busy")
    // a pending result is never overwritten
    `AST_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && m_tvalid, "result register overwritten")
    // level step only on a finished modulo run
    `AST_HOLDS(a_step_after_div, clk, rst_n, cmd.step |-> stat.div_done, "step without divider result")
    // counter never advances past the end of a fade
    `AST_HOLDS(a_tick_in_range, clk, rst_n, cmd.tick_end |-> !stat.count_over, "tick after fade end")

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top.sv - self-checking bench for the rgb_crossfade_stepper LED crossfader.
// Needs rcs_pkg and the RTL of rgb_crossfade_stepper; a table of directed items comes first,
// then random fades checked against a cycle-free model of the fade arithmetic.

module tb_top;
    import rcs_pkg::*;

    localparam int FADE_LEN     = FADE_TICKS_DEF;
    localparam int RAND_ITEMS   = 850;
    localparam int HOLD_CYCLES  = 600;    // long output back-pressure, fills the block
    localparam int TAIL_CYCLES  = 200;    // idle wait after the last result is back
    localparam int DIR_N        = 23;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result fields, as they come out of m_tdata / m_tuser
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fading;
    } rgb_result_t;

    // one directed item; want is used only when typed is set
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        bit          typed;
        rgb_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    logic [1:0]  s_tuser;     // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    logic [0:0]  m_tuser;     // [0] fading

    rgb_crossfade_stepper uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Crossfade model: own copy of the block state
    // ------------------------------------------------------------------
    logic [10:0] fade_pos;        // tick counter, holds at FADE_LEN+1 when done
    logic [7:0]  cur_lvl  [3];    // drive levels
    logic [7:0]  from_lvl [3];    // colour the next fade starts from
    int          step_ivl [3];    // signed ticks per one-level step, 0 = frozen

    rgb_result_t level_q [$];     // levels awaiting their result item
    int          mismatch_cnt = 0;
    int          fed = 0;         // accepted items that the block acts on
    int          burst_left = 0;
    bit          hold_req = 1'b0; // sender asks receiver for a long hold-off

    function automatic rgb_result_t crossfade_next(logic [1:0] op, logic [23:0] chans);
        int c;
        int target;
        int gap;
        int mag;
        int v;
        rgb_result_t res;
        case (op)
            OP_TICK: begin
                if (fade_pos <= FADE_LEN) begin
                    for (c = 0; c < 3; c++) begin
                        // percent -> level only on the first tick; may exceed 255
                        if (fade_pos == 0) begin
                            target = int'(chans[8*c +: 8]) * 255 / 100;
                            gap    = target - int'(from_lvl[c]);
                            mag    = (gap < 0) ? -gap : gap;
                            if (gap == 0)
                                step_ivl[c] = 0;
                            else
                                step_ivl[c] = (gap < 0) ? -(FADE_LEN / mag) : FADE_LEN / mag;
                        end
                        v = int'(cur_lvl[c]);
                        if (step_ivl[c] != 0) begin
                            mag = (step_ivl[c] < 0) ? -step_ivl[c] : step_ivl[c];
                            if (int'(fade_pos) % mag == 0)
                                v += (step_ivl[c] > 0) ? 1 : -1;
                        end
                        if (v > 255)
                            v = 255;
                        if (v < 0)
                            v = 0;
                        cur_lvl[c] = v[7:0];
                    end
                    fade_pos++;
                    // fade just finished: levels become the next start colour
                    if (fade_pos > FADE_LEN)
                        from_lvl = cur_lvl;
                end
            end
            OP_SET: begin
                for (c = 0; c < 3; c++) begin
                    cur_lvl[c]  = chans[8*c +: 8];
                    from_lvl[c] = chans[8*c +: 8];
                end
            end
            OP_RESTART: fade_pos = '0;
            default: ;   // unused op leaves everything alone
        endcase
        res.red    = cur_lvl[0];
        res.green  = cur_lvl[1];
        res.blue   = cur_lvl[2];
        res.fading = (fade_pos <= FADE_LEN);
        return res;
    endfunction

    function automatic logic [23:0] rnd24();
        logic [31:0] w;
        w = $urandom();
        return w[23:0];
    endfunction

    // three percent targets: mostly 0..100, some above (no saturation there)
    function automatic logic [23:0] pct_triplet();
        logic [23:0] p;
        int c;
        for (c = 0; c < 3; c++) begin
            case ($urandom_range(0, 9))
                0:       p[8*c +: 8] = 8'd0;
                1:       p[8*c +: 8] = 8'd255;
                2, 3:    p[8*c +: 8] = 8'($urandom_range(101, 255));
                default: p[8*c +: 8] = 8'($urandom_range(0, 100));
            endcase
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Sender side: bursts of items with random gaps
    // ------------------------------------------------------------------
    task automatic offer(input logic [1:0] op, input logic [23:0] data,
                         input bit typed, input rgb_result_t typed_res);
        rgb_result_t res;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // long bursts now and then give stretches with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = crossfade_next(op, data);
        level_q.push_back(typed ? typed_res : res);
        if (op != OP_UNUSED)
            fed++;
    endtask

    // sender stops until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (level_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Directed items. Typed expectations only where obvious.
    // ------------------------------------------------------------------
    stim_row_t dir_rows [DIR_N] = '{
        // first tick after reset, all gaps zero: nothing moves
        '{OP_TICK,    8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{OP_RESTART, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        // unused op with all-ones data is ignored
        '{OP_UNUSED,  8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{OP_SET,     8'd255, 8'd0,   8'd128, 1'b1, '{8'd255, 8'd0,   8'd128, 1'b1}},
        // over-range percent, upward and downward gaps, clamp at 255
        '{OP_TICK,    8'd255, 8'd100, 8'd0,   1'b0, '0},
        '{OP_TICK,    8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_TICK,    8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_TICK,    8'd0,   8'd0,   8'd0,   1'b0, '0},
        // set mid-fade keeps counter and intervals
        '{OP_SET,     8'd0,   8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b1}},
        '{OP_TICK,    8'd50,  8'd50,  8'd50,  1'b0, '0},
        '{OP_UNUSED,  8'd170, 8'd85,  8'd15,  1'b0, '0},
        '{OP_RESTART, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        // 101% lands above 255, large gap down, zero gap
        '{OP_TICK,    8'd101, 8'd1,   8'd100, 1'b0, '0},
        '{OP_TICK,    8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{OP_SET,     8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{OP_RESTART, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        // smallest nonzero gap: longest interval
        '{OP_TICK,    8'd1,   8'd1,   8'd1,   1'b0, '0},
        '{OP_TICK,    8'd0,   8'd255, 8'd99,  1'b0, '0},
        '{OP_SET,     8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
        '{OP_RESTART, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
        '{OP_TICK,    8'd100, 8'd100, 8'd100, 1'b0, '0},
        '{OP_TICK,    8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_SET,     8'h55,  8'hAA,  8'h0F,  1'b1, '{8'h55,  8'hAA,  8'h0F,  1'b1}}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int i;
        int n;
        int kind;
        bit hold_done;
        bit pause_done;
        logic [1:0] rop;

        hold_done  = 1'b0;
        pause_done = 1'b0;
        fade_pos   = '0;
        for (i = 0; i < 3; i++) begin
            cur_lvl[i]  = '0;
            from_lvl[i] = '0;
            step_ivl[i] = 0;
        end
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TICK;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
            offer(dir_rows[i].op, {dir_rows[i].blue, dir_rows[i].green, dir_rows[i].red},
                  dir_rows[i].typed, dir_rows[i].want);

        // random part: mostly well-formed fades with random content, some noise
        while (fed < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // a restart is skipped now and then so a fade runs on
                if ($urandom_range(0, 5) != 0)
                    offer(OP_RESTART, rnd24(), 1'b0, '0);
                if ($urandom_range(0, 1) == 0)
                    offer(OP_SET, rnd24(), 1'b0, '0);
                n = $urandom_range(1, 40);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        offer(OP_SET, rnd24(), 1'b0, '0);
                    offer(OP_TICK, pct_triplet(), 1'b0, '0);
                end
            end else if (kind < 9) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    rop = 2'($urandom_range(0, 3));
                    offer(rop, rnd24(), 1'b0, '0);
                end
            end else begin
                offer(OP_UNUSED, rnd24(), 1'b0, '0);
            end

            // receiver holds off long while items keep coming
            if (!hold_done && fed > 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && fed > 550) begin
                drain_results();
                pause_done = 1'b1;
            end
        end

        // one complete fade: end of fade latches start colour, then idle ticks
        offer(OP_RESTART, rnd24(), 1'b0, '0);
        offer(OP_SET, rnd24(), 1'b0, '0);
        offer(OP_TICK, pct_triplet(), 1'b0, '0);
        n = FADE_LEN + $urandom_range(2, 8);
        for (i = 0; i < n; i++)
            offer(OP_TICK, rnd24(), 1'b0, '0);
        // next fade starts from the latched colour
        offer(OP_RESTART, rnd24(), 1'b0, '0);
        offer(OP_TICK, pct_triplet(), 1'b0, '0);
        for (i = 0; i < 30; i++)
            offer(OP_TICK, rnd24(), 1'b0, '0);

        s_tvalid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: stalls on its own pattern, plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int run;
        int k;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 2);
            run  = $urandom_range(10, 80);
            for (k = 0; k < run; k++) begin
                case (mode)
                    0:       m_tready <= 1'b1;                         // no stalls
                    1:       m_tready <= ($urandom_range(0, 3) != 0);  // sparse random
                    default: m_tready <= ((k % 7) < 4);                // fixed duty
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ERROR %s: expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk) begin
        rgb_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (level_q.size() == 0) begin
                $display("%0t ERROR unexpected result: expected none, got %h / %b",
                         $time, m_tdata, m_tuser);
                mismatch_cnt++;
            end else begin
                want = level_q.pop_front();
                check_field("red_out",   want.red,    m_tdata[7:0]);
                check_field("green_out", want.green,  m_tdata[15:8]);
                check_field("blue_out",  want.blue,   m_tdata[23:16]);
                check_field("fading",    want.fading, m_tuser[0]);
            end
        end
    end

    // Watchdog: well above the slowest legal run (~2000 items)
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[rgb_crossfade_stepper.f]
+incdir+rtl
rtl/rcs_pkg.sv
rtl/rcs_div.sv
rtl/rcs_dpath.sv
rtl/rcs_ctrl.sv
rtl/rgb_crossfade_stepper.sv
tb/tb_top.sv
